/* rtl/core/sspg_pkg.sv */
// Shared types, constants and helpers for the step pulse generator core.
// No dependencies; every module of the core imports this package.
package sspg_pkg;

	localparam int MOTORS = 4;
	localparam int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1;

	localparam int WORD_W = 32;
	localparam int HP_W   = 19;
	localparam int DOSE_W = 16;
	localparam int QUO_W  = 20;

	// Step clock in Hz; quotient of this over the dose is the full period.
	localparam logic [QUO_W-1:0] STEP_CLOCK_HZ   = QUO_W'(1000000);
	localparam logic [HP_W-1:0]  MIN_HALF_PERIOD = HP_W'(4);

	// Item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_SETUP = 2'd1;
	localparam logic [1:0] KIND_RUN   = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	// Configuration register indexes
	localparam logic REG_DIR_INVERT  = 1'b0;
	localparam logic REG_EXT_FEEDBACK = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HP_W-1:0]   hp_t;

	// Outcome of evaluating one motor on a tick
	typedef struct packed {
		logic  toggle;
		logic  phase;
		word_t count;
	} tick_res_t;

	// Mask bits exist for motors 0..3 only
	function automatic logic mask_bit(input logic [3:0] mask, input int unsigned m);
		logic b;
		b = 1'b0;
		if (m < 4)
			b = mask[m[1:0]];
		return b;
	endfunction

endpackage

/* rtl/core/sspg_div.sv */
// Restoring divider: STEP_CLOCK_HZ divided by the dose, one quotient bit per cycle.
// Depends on sspg_pkg.
module sspg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sspg_pkg::DOSE_W-1:0]   divisor,
	output logic                          done,
	output logic [sspg_pkg::QUO_W-1:0]    quotient
);
	import sspg_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [QUO_W-1:0]    dvd_q;
	logic [DOSE_W-1:0]   rem_q;
	logic [DOSE_W-1:0]   div_q;
	logic [DOSE_W:0]     trial;
	logic [DOSE_W:0]     diff;
	logic                fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= STEP_CLOCK_HZ;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DOSE_W-1:0] : trial[DOSE_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* rtl/core/sspg_tick_unit.sv */
// Shared elapsed-time compare and pulse counter for one motor per cycle.
// Depends on sspg_pkg.
module sspg_tick_unit (
	input  sspg_pkg::word_t     time_now,
	input  sspg_pkg::word_t     last_toggle,
	input  sspg_pkg::hp_t       half_period,
	input  logic                phase,
	input  sspg_pkg::word_t     count,
	input  logic                ext_feedback,
	output sspg_pkg::tick_res_t res
);
	import sspg_pkg::*;

	word_t elapsed;
	logic  toggle;

	assign elapsed = time_now - last_toggle;
	assign toggle  = (half_period != '0) && (elapsed >= WORD_W'(half_period));

	always_comb begin
		res.toggle = toggle;
		res.phase  = toggle ? ~phase : phase;
		res.count  = count;
		// count on the falling edge unless the motor reports its own feedback
		if (toggle && phase && !ext_feedback)
			res.count = count + WORD_W'(1);
	end

endmodule

/* rtl/core/stepper_step_pulse_generator_core.sv */
// Step pulse generator for MOTORS channels: time base, per-motor state and sequencer.
// Depends on sspg_pkg, sspg_div and sspg_tick_unit.
//
// Each input item produces exactly one result item carrying the step and
// direction line levels after the item, the pulse count of the addressed motor
// and a dose error flag. A tick advances the microsecond counter and then walks
// the motors one per cycle through a single shared compare/increment unit.
// A run item with nonzero speed and dose runs the shared restoring divider,
// one quotient bit per cycle over 20 bits. Setup, stop and run items that halt
// the motor skip the divider and go straight to the result. The input side
// stalls while an item is in work; a finished result waits in the output
// register so a new item can be taken before it is collected. Configuration
// writes are always ready and take effect at once; write them only while idle.
module stepper_step_pulse_generator_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  motor,
	input  logic signed [15:0] speed,
	input  logic [15:0] dose,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  step_lines,
	output logic [3:0]  direction_lines,
	output logic [31:0] pulse_count,
	output logic        dose_error,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import sspg_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   motor_q;
	logic               motor_ok_q;
	logic               err_q;

	// time base and per-motor state
	word_t              time_q;
	word_t              last_q   [MOTORS];
	hp_t                hp_q     [MOTORS];
	logic               phase_q  [MOTORS];
	logic               level_q  [MOTORS];
	logic               dir_q    [MOTORS];
	word_t              count_q  [MOTORS];

	logic [3:0]         dir_inv_q;
	logic [3:0]         ext_fb_q;

	// output register
	logic               out_valid_q;
	logic [3:0]         step_lines_q;
	logic [3:0]         direction_lines_q;
	word_t              pulse_count_q;
	logic               dose_error_q;

	logic               in_acc;
	logic               in_ok;
	logic [IDX_W-1:0]   in_idx;
	logic               div_start;
	logic               div_done;
	logic [QUO_W-1:0]   quotient;
	hp_t                hp_new;
	tick_res_t          tick_res;
	logic [3:0]         step_vec;
	logic [3:0]         dir_vec;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign in_ok     = (int'(motor) < MOTORS);
	assign in_idx    = IDX_W'(motor);
	assign cfg_ready = 1'b1;

	// divide only for a real run request; zero speed or dose halts at once
	assign div_start = in_acc && in_ok && (kind == KIND_RUN) &&
		(speed != '0) && (dose != '0);

	sspg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (dose),
		.done     (div_done),
		.quotient (quotient)
	);

	// half of the full period, floored at the minimum
	assign hp_new = (quotient[QUO_W-1:1] < MIN_HALF_PERIOD) ?
		MIN_HALF_PERIOD : quotient[QUO_W-1:1];

	sspg_tick_unit u_tick (
		.time_now     (time_q),
		.last_toggle  (last_q[idx_q]),
		.half_period  (hp_q[idx_q]),
		.phase        (phase_q[idx_q]),
		.count        (count_q[idx_q]),
		.ext_feedback (mask_bit(ext_fb_q, int'(idx_q))),
		.res          (tick_res)
	);

	// gather line levels of the motors that have a line bit
	always_comb begin
		step_vec = '0;
		dir_vec  = '0;
		for (int i = 0; i < MOTORS && i < 4; i++) begin
			step_vec[i] = level_q[i];
			dir_vec[i]  = dir_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			idx_q             <= '0;
			motor_q           <= '0;
			motor_ok_q        <= 1'b0;
			err_q             <= 1'b0;
			out_valid_q       <= 1'b0;
			step_lines_q      <= '0;
			direction_lines_q <= '0;
			pulse_count_q     <= '0;
			dose_error_q      <= 1'b0;
			time_q            <= '0;
			dir_inv_q         <= '0;
			ext_fb_q          <= '0;
			for (int i = 0; i < MOTORS; i++) begin
				last_q[i]  <= '0;
				hp_q[i]    <= '0;
				phase_q[i] <= 1'b0;
				level_q[i] <= 1'b0;
				dir_q[i]   <= 1'b0;
				count_q[i] <= '0;
			end
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DIR_INVERT:   dir_inv_q <= cfg_data;
					REG_EXT_FEEDBACK: ext_fb_q  <= cfg_data;
					default:          ;
				endcase
			end

			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						motor_q    <= in_idx;
						motor_ok_q <= in_ok;
						err_q      <= 1'b0;
						if (kind == KIND_TICK) begin
							time_q  <= time_q + WORD_W'(1);
							idx_q   <= '0;
							state_q <= ST_TICK;
						end else begin
							// a real run request goes through the divider first
							state_q <= div_start ? ST_DIV : ST_DONE;
							if (in_ok) begin
								unique case (kind)
									KIND_SETUP: begin
										hp_q[in_idx]    <= '0;
										last_q[in_idx]  <= time_q + WORD_W'(1);
										level_q[in_idx] <= 1'b0;
										dir_q[in_idx]   <=
											~mask_bit(dir_inv_q, int'(in_idx));
										if (!mask_bit(ext_fb_q, int'(in_idx)))
											count_q[in_idx] <= '0;
									end
									KIND_RUN: begin
										if (speed == '0) begin
											hp_q[in_idx]    <= '0;
											level_q[in_idx] <= 1'b0;
										end else if (dose == '0) begin
											hp_q[in_idx]    <= '0;
											level_q[in_idx] <= 1'b0;
											err_q           <= 1'b1;
										end
									end
									KIND_STOP: begin
										hp_q[in_idx]    <= '0;
										level_q[in_idx] <= 1'b0;
									end
									default: ;
								endcase
							end
						end
					end
				end

				ST_TICK: begin
					// advance one motor per cycle through the shared unit
					if (tick_res.toggle) begin
						last_q[idx_q]  <= time_q;
						phase_q[idx_q] <= tick_res.phase;
						level_q[idx_q] <= tick_res.phase;
						count_q[idx_q] <= tick_res.count;
					end
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(MOTORS - 1))
						state_q <= ST_DONE;
				end

				ST_DIV: begin
					if (div_done) begin
						hp_q[motor_q] <= hp_new;
						state_q       <= ST_DONE;
					end
				end

				ST_DONE: begin
					// publish once the output register is free or being emptied
					if (!out_valid_q || !out_stall) begin
						out_valid_q       <= 1'b1;
						step_lines_q      <= step_vec;
						direction_lines_q <= dir_vec;
						pulse_count_q     <= motor_ok_q ? count_q[motor_q] : '0;
						dose_error_q      <= err_q;
						state_q           <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign step_lines      = step_lines_q;
	assign direction_lines = direction_lines_q;
	assign pulse_count     = pulse_count_q;
	assign dose_error      = dose_error_q;

endmodule

/* bench/stepper_step_pulse_generator_core_tb.sv */
// Self-checking testbench for stepper_step_pulse_generator_core.
// Depends on sspg_pkg and the core; predicts every result item in-bench and
// checks it field by field against what the core returns.
`timescale 1ns / 100ps

module stepper_step_pulse_generator_core_tb;
	import sspg_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	// One result item as the core returns it
	typedef struct {
		logic [3:0]  step;
		logic [3:0]  dir;
		logic [31:0] count;
		logic        err;
	} pulse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_TICK;
	logic [1:0]  motor = 2'd0;
	logic signed [15:0] speed = 16'sd0;
	logic [15:0] dose = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  step_lines;
	logic [3:0]  direction_lines;
	logic [31:0] pulse_count;
	logic        dose_error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_DIR_INVERT;
	logic [3:0]  cfg_data = 4'd0;

	stepper_step_pulse_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.motor(motor),
		.speed(speed),
		.dose(dose),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.step_lines(step_lines),
		.direction_lines(direction_lines),
		.pulse_count(pulse_count),
		.dose_error(dose_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the pulse generator state
	word_t              usec_now = '0;
	word_t              toggle_stamp [MOTORS];
	hp_t                half_per [MOTORS];
	logic [MOTORS-1:0]  phase_bits = '0;
	logic [MOTORS-1:0]  step_bits = '0;
	logic [MOTORS-1:0]  dir_bits = '0;
	word_t              pulse_tally [MOTORS];
	logic [3:0]         invert_mask = 4'd0;
	logic [3:0]         feedback_mask = 4'd0;

	pulse_result_t expected_results [$];
	pulse_result_t wanted;
	int            failures = 0;
	int            items_sent = 0;
	int            cycle_count = 0;
	int            stall_left = 0;
	// Calm stretches: no new random gaps or stalls begin while this is set
	logic          calm = 1'b0;

	initial begin
		for (int i = 0; i < MOTORS; i++) begin
			toggle_stamp[i] = '0;
			half_per[i] = '0;
			pulse_tally[i] = '0;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Advance the shadow state by one item and queue the result it must give
	task automatic predict_item(input logic [1:0] k, input logic [1:0] m,
			input logic [15:0] spd, input logic [15:0] dz);
		pulse_result_t r;
		word_t quo;
		r.err = 1'b0;
		case (k)
			KIND_TICK: begin
				usec_now = usec_now + 1;
				for (int i = 0; i < MOTORS; i++) begin
					if (half_per[i] != '0 &&
							word_t'(usec_now - toggle_stamp[i]) >= word_t'(half_per[i])) begin
						toggle_stamp[i] = usec_now;
						phase_bits[i] = ~phase_bits[i];
						step_bits[i] = phase_bits[i];
						// count on the falling edge unless feedback comes from outside
						if (!phase_bits[i] && !feedback_mask[i])
							pulse_tally[i] = pulse_tally[i] + 1;
					end
				end
			end
			KIND_SETUP: begin
				half_per[m] = '0;
				toggle_stamp[m] = usec_now + 1;
				step_bits[m] = 1'b0;
				dir_bits[m] = ~invert_mask[m];
				if (!feedback_mask[m])
					pulse_tally[m] = '0;
			end
			KIND_RUN: begin
				if (spd == 16'd0) begin
					half_per[m] = '0;
					step_bits[m] = 1'b0;
				end else if (dz == 16'd0) begin
					half_per[m] = '0;
					step_bits[m] = 1'b0;
					r.err = 1'b1;
				end else begin
					quo = (word_t'(STEP_CLOCK_HZ) / word_t'(dz)) / 2;
					if (quo < word_t'(MIN_HALF_PERIOD))
						quo = word_t'(MIN_HALF_PERIOD);
					half_per[m] = hp_t'(quo);
				end
			end
			KIND_STOP: begin
				half_per[m] = '0;
				step_bits[m] = 1'b0;
			end
		endcase
		r.step = step_bits[3:0];
		r.dir = dir_bits[3:0];
		r.count = pulse_tally[m];
		expected_results.push_back(r);
	endtask

	// Offer one item, hold it until taken, then maybe idle. Call and return at a falling edge.
	task automatic send_item(input logic [1:0] k, input logic [1:0] m,
			input logic [15:0] spd, input logic [15:0] dz);
		int gap;
		in_valid = 1'b1;
		kind = k;
		motor = m;
		speed = spd;
		dose = dz;
		do @(posedge clk); while (in_stall);
		predict_item(k, m, spd, dz);
		items_sent++;
		@(negedge clk);
		gap = (!calm && $urandom_range(0, 99) < 35) ? idle_length() : 0;
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid and hold off until every queued result has come back
	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write one configuration register while the core is idle
	task automatic write_reg(input logic idx, input logic [3:0] val);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DIR_INVERT)
			invert_mask = val;
		else
			feedback_mask = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Steps per second for a run: mostly fast enough to toggle within a few dozen ticks
	function automatic logic [15:0] run_dose();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 16'($urandom_range(15000, 65535));
		if (r < 80)
			return 16'($urandom_range(2000, 15000));
		if (r < 95)
			return 16'($urandom_range(1, 65535));
		return 16'd0;
	endfunction

	// Speed for a run: nonzero most of the time, any bit pattern
	function automatic logic [15:0] run_speed();
		if ($urandom_range(0, 99) < 8)
			return 16'd0;
		return 16'($urandom_range(1, 65535));
	endfunction

	// Start three motors, cover speed and dose extremes, the dose error and stop
	task automatic test_directed_motion();
		send_item(KIND_TICK, 2'd0, 16'h0000, 16'h0000);
		send_item(KIND_SETUP, 2'd0, 16'h0000, 16'h0000);
		// fastest dose: half period of 7
		send_item(KIND_RUN, 2'd0, 16'h7fff, 16'hffff);
		// slowest dose on a motor never set up
		send_item(KIND_RUN, 2'd1, 16'h8000, 16'h0001);
		// zero speed halts the motor
		send_item(KIND_RUN, 2'd2, 16'h0000, 16'h04d2);
		// zero dose halts it and raises the error flag
		send_item(KIND_RUN, 2'd3, 16'h0001, 16'h0000);
		send_item(KIND_SETUP, 2'd3, 16'hffff, 16'hffff);
		send_item(KIND_RUN, 2'd3, 16'hffff, 16'd62500);
		// walk the reported motor so each count shows up
		for (int i = 0; i < 17; i++)
			send_item(KIND_TICK, 2'(i), 16'($urandom), 16'($urandom));
		send_item(KIND_STOP, 2'd0, 16'h0000, 16'h0000);
	endtask

	// Invert and feedback masks at their extremes: no counting, no clearing
	task automatic test_feedback_masks();
		write_reg(REG_DIR_INVERT, 4'hf);
		write_reg(REG_EXT_FEEDBACK, 4'hf);
		for (int i = 0; i < MOTORS; i++)
			send_item(KIND_SETUP, 2'(i), 16'h0000, 16'h0000);
		send_item(KIND_RUN, 2'd0, 16'h1234, 16'hffff);
		send_item(KIND_RUN, 2'd2, 16'hfedc, 16'd40000);
		for (int i = 0; i < 20; i++)
			send_item(KIND_TICK, 2'(i), 16'($urandom), 16'($urandom));
		// back to internal feedback: counting resumes and setup clears again
		write_reg(REG_EXT_FEEDBACK, 4'h0);
		for (int i = 0; i < 16; i++)
			send_item(KIND_TICK, 2'(i), 16'($urandom), 16'($urandom));
		send_item(KIND_SETUP, 2'd1, 16'h0000, 16'h0000);
		send_item(KIND_STOP, 2'd2, 16'h0000, 16'h0000);
	endtask

	// Random setup/run/tick sequences with noise mixed in
	task automatic test_random_traffic(input int count);
		int target;
		int r;
		logic [1:0] m;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			m = 2'($urandom_range(0, 3));
			if (r < 45) begin
				repeat ($urandom_range(1, 12))
					send_item(KIND_TICK, 2'($urandom), 16'($urandom), 16'($urandom));
			end else if (r < 63) begin
				send_item(KIND_RUN, m, run_speed(), run_dose());
			end else if (r < 77) begin
				// a well-formed start: setup, then run the same motor
				send_item(KIND_SETUP, m, 16'($urandom), 16'($urandom));
				send_item(KIND_RUN, m, run_speed(), run_dose());
			end else if (r < 84) begin
				send_item(KIND_STOP, m, 16'($urandom), 16'($urandom));
			end else if (r < 93) begin
				send_item(2'($urandom), m, 16'($urandom), 16'($urandom));
			end else if (r < 96) begin
				wait_drained();
			end else begin
				calm = ~calm;
			end
		end
		calm = 1'b0;
	endtask

	// Receiver: stall at random, with calm stretches
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			stall_left = idle_length() - 1;
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result with nothing expected: step %h dir %h count %0d err %b",
						step_lines, direction_lines, pulse_count, dose_error);
			end else begin
				wanted = expected_results.pop_front();
				if (step_lines !== wanted.step || direction_lines !== wanted.dir ||
						pulse_count !== wanted.count || dose_error !== wanted.err) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: step %h/%h dir %h/%h count %0d/%0d err %b/%b (exp/got)",
							wanted.step, step_lines, wanted.dir, direction_lines,
							wanted.count, pulse_count, wanted.err, dose_error);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("stepper_step_pulse_generator_core verification failed");
			$finish;
		end
	end

	initial begin
		// Hold reset, then release it at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_motion();
		test_feedback_masks();

		write_reg(REG_DIR_INVERT, 4'h0);
		write_reg(REG_EXT_FEEDBACK, 4'h0);
		test_random_traffic(450);

		write_reg(REG_DIR_INVERT, 4'hf);
		write_reg(REG_EXT_FEEDBACK, 4'hf);
		test_random_traffic(450);

		write_reg(REG_DIR_INVERT, 4'h5);
		write_reg(REG_EXT_FEEDBACK, 4'ha);
		test_random_traffic(450);

		write_reg(REG_DIR_INVERT, 4'($urandom));
		write_reg(REG_EXT_FEEDBACK, 4'($urandom));
		test_random_traffic(450);

		// Drain, then let the pipeline settle before judging
		wait_drained();
		repeat (40) @(posedge clk);
		failures += expected_results.size();
		if (failures == 0)
			$display("stepper_step_pulse_generator_core verification clean");
		else
			$display("stepper_step_pulse_generator_core verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/sspg_pkg.sv
rtl/core/sspg_div.sv
rtl/core/sspg_tick_unit.sv
rtl/core/stepper_step_pulse_generator_core.sv
bench/stepper_step_pulse_generator_core_tb.sv
